FILE: hdl/bpra_pkg.sv
// bpra_pkg: types and constants shared by the page run allocator modules
// no dependencies
`default_nettype none

package bpra_pkg;

  localparam int unsigned WORD_BITS  = 32;   // pages per bitmap word
  localparam int unsigned BIT_W      = 5;    // bit index within a word
  localparam int unsigned RUN_W      = 11;   // page counts and region size
  localparam int unsigned ADDR_W     = 32;   // virtual addresses
  localparam int unsigned PAGE_SHIFT = 12;   // 4 KiB pages
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_NO_SPACE      = 2'd1,
    ST_OUT_OF_REGION = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_REGION_PAGES = 1'b1
  } cfg_reg_e;

  // outcome of running one bitmap word through the run finder
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] end_bit;
    logic [RUN_W-1:0] run_out;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: hdl/bpra_run_scan.sv
// bpra_run_scan: finds where a run of free pages reaches the wanted length in one word
// depends on bpra_pkg
`default_nettype none

module bpra_run_scan import bpra_pkg::*; (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [RUN_W-1:0]     run_i,
  input  logic [RUN_W-1:0]     count_i,
  output scan_res_t            res_o
);

  logic             seen [BIT_W+1][WORD_BITS];
  logic [BIT_W-1:0] pos  [BIT_W+1][WORD_BITS];
  logic [RUN_W:0]   run_len [WORD_BITS];
  logic [WORD_BITS-1:0] hit;

  // prefix scan for the nearest allocated page at or below each bit
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      seen[0][j] = !word_i[j];
      pos[0][j]  = BIT_W'(j);
    end
    for (int l = 0; l < BIT_W; l++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if ((j >= (1 << l)) && !seen[l][j]) begin
          seen[l+1][j] = seen[l][j - (1 << l)];
          pos[l+1][j]  = pos[l][j - (1 << l)];
        end else begin
          seen[l+1][j] = seen[l][j];
          pos[l+1][j]  = pos[l][j];
        end
      end
    end
  end

  // run length ending at each bit, first bit where it meets the count
  always_comb begin
    res_o = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!word_i[j]) begin
        run_len[j] = '0;
      end else if (seen[BIT_W][j]) begin
        run_len[j] = (RUN_W+1)'(j) - (RUN_W+1)'(pos[BIT_W][j]);
      end else begin
        run_len[j] = (RUN_W+1)'(run_i) + (RUN_W+1)'(j) + (RUN_W+1)'(1);
      end
      hit[j] = word_i[j] && (run_len[j] == (RUN_W+1)'(count_i));
    end
    res_o.found = |hit;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        res_o.end_bit = BIT_W'(j);
      end
    end
    res_o.run_out = run_len[WORD_BITS-1][RUN_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hdl/bitmap_page_run_allocator.sv
// bitmap_page_run_allocator: first-fit allocator of contiguous 4 KiB page runs
// depends on bpra_pkg and bpra_run_scan
//
// channel   dir  fields (lsb first)                          accepted when
// s_axis    in   tdata: page_count[10:0], page_address[42:11]  tvalid & tready
//                tuser: opcode[0]
// m_axis    out  tdata: run_address[31:0], status[33:32]        tvalid & tready
// cfg       in   index 0 base_address, 1 region_pages           cfg_we_i
//
// an allocate scans the bitmap word by word until the run is found or the
// region ends, then sets up, clears each word the run touches and hands off;
// a free reads and rewrites one word and hands off; the bitmap memory has one
// read port and one write port; after reset and after each region_pages write
// a fill pass reloads the bitmap word by word; no item is taken during it
// the result sits in an output register, so a new item is taken while it waits
`default_nettype none

module bitmap_page_run_allocator import bpra_pkg::*; #(
  parameter int unsigned MAX_PAGES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // page_count[10:0], page_address[42:11], zero pad above
  input  logic [47:0]           s_axis_tdata,
  // opcode[0]
  input  logic [0:0]            s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // run_address[31:0], status[33:32], zero pad above
  output logic [39:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ADDR_W-1:0]     cfg_data_i
);

  localparam int unsigned WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PW     = AW + BIT_W;
  localparam int unsigned MaxLim = (MAX_PAGES > 2047) ? 2047 : MAX_PAGES;

  typedef enum logic [6:0] {
    S_FILL  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SETUP = 7'b0001000,
    S_MARK  = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  // input payload
  logic [RUN_W-1:0]  in_count;
  logic [ADDR_W-1:0] in_addr;
  opcode_e           in_op;
  assign in_count = s_axis_tdata[10:0];
  assign in_addr  = s_axis_tdata[42:11];
  assign in_op    = opcode_e'(s_axis_tuser[0]);

  state_e            state_q, state_d;
  logic [AW-1:0]     wcnt_q, wcnt_d;       // word counter for fill, scan and mark
  logic [RUN_W-1:0]  run_q, run_d;         // free run carried into the next word
  logic [RUN_W-1:0]  count_q, count_d;
  logic [PW-1:0]     end_q, end_d;         // last page of the found run
  logic [PW-1:0]     start_q, start_d;
  logic [PW-1:0]     page_q, page_d;       // page being freed
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] base_q;
  logic [RUN_W-1:0]  region_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  status_e           out_status_q;

  // bitmap memory, one free bit per page
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic                 mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // active region, clamped to the bitmap size
  logic [RUN_W-1:0] n_pages;
  logic [RUN_W:0]   n_words;
  assign n_pages = (region_q > RUN_W'(MaxLim)) ? RUN_W'(MaxLim) : region_q;
  assign n_words = ((RUN_W+1)'(n_pages) + (RUN_W+1)'(WORD_BITS - 1)) >> BIT_W;

  // fill pattern: ones below the region edge
  logic [WORD_BITS-1:0] fill_word;
  always_comb begin
    if (16'(wcnt_q) < 16'(n_pages[RUN_W-1:BIT_W])) begin
      fill_word = '1;
    end else if (16'(wcnt_q) == 16'(n_pages[RUN_W-1:BIT_W])) begin
      fill_word = (WORD_BITS'(1) << n_pages[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      fill_word = '0;
    end
  end

  // free request address check
  logic [ADDR_W-1:0] free_diff;
  logic              free_ok;
  assign free_diff = in_addr - base_q;
  assign free_ok   = (in_addr >= base_q) &&
                     (free_diff[ADDR_W-1:PAGE_SHIFT] < 20'(n_pages));

  // run finder over the word just read
  scan_res_t scan_res;
  bpra_run_scan u_scan (
    .word_i  (rdata_q),
    .run_i   (run_q),
    .count_i (count_q),
    .res_o   (scan_res)
  );

  // clear mask for the word under marking
  logic [BIT_W-1:0]     mark_lo, mark_hi;
  logic [WORD_BITS-1:0] mark_mask;
  always_comb begin
    mark_lo   = (wcnt_q == start_q[PW-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
    mark_hi   = (wcnt_q == end_q[PW-1:BIT_W]) ? end_q[BIT_W-1:0] : '1;
    mark_mask = ({WORD_BITS{1'b1}} << mark_lo) &
                ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mark_hi));
  end

  logic out_load;
  assign out_load = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d      = state_q;
    wcnt_d       = wcnt_q;
    run_d        = run_q;
    count_d      = count_q;
    end_d        = end_q;
    start_d      = start_q;
    page_d       = page_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = wcnt_q;
    mem_wdata    = fill_word;
    mem_raddr    = '0;

    unique case (state_q)
      S_FILL: begin
        mem_we = 1'b1;
        if (wcnt_q == AW'(WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          wcnt_d = wcnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        mem_raddr = '0;
        if (s_axis_tvalid) begin
          res_addr_d = '0;
          if (in_op == OP_ALLOC) begin
            if ((in_count == '0) || (in_count > n_pages)) begin
              res_status_d = ST_NO_SPACE;
              state_d      = S_RESP;
            end else begin
              wcnt_d  = '0;
              run_d   = '0;
              count_d = in_count;
              state_d = S_SCAN;
            end
          end else begin
            page_d = free_diff[PAGE_SHIFT +: PW];
            if (free_ok) begin
              mem_raddr = free_diff[PAGE_SHIFT + BIT_W +: AW];
              state_d   = S_FREE;
            end else begin
              res_status_d = ST_OUT_OF_REGION;
              state_d      = S_RESP;
            end
          end
        end
      end
      S_SCAN: begin
        mem_raddr = wcnt_q + AW'(1);
        if (scan_res.found) begin
          end_d   = {wcnt_q, scan_res.end_bit};
          state_d = S_SETUP;
        end else if ((RUN_W+1)'(wcnt_q) + (RUN_W+1)'(1) >= n_words) begin
          res_status_d = ST_NO_SPACE;
          state_d      = S_RESP;
        end else begin
          run_d  = scan_res.run_out;
          wcnt_d = wcnt_q + AW'(1);
        end
      end
      S_SETUP: begin
        start_d   = PW'(17'(end_q) - 17'(count_q) + 17'd1);
        mem_raddr = start_d[PW-1:BIT_W];
        wcnt_d    = start_d[PW-1:BIT_W];
        state_d   = S_MARK;
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q & ~mark_mask;
        mem_raddr = wcnt_q + AW'(1);
        if (wcnt_q == end_q[PW-1:BIT_W]) begin
          res_addr_d   = base_q + ADDR_W'({start_q, {PAGE_SHIFT{1'b0}}});
          res_status_d = ST_OK;
          state_d      = S_RESP;
        end else begin
          wcnt_d = wcnt_q + AW'(1);
        end
      end
      S_FREE: begin
        mem_we       = 1'b1;
        mem_waddr    = page_q[PW-1:BIT_W];
        mem_wdata    = rdata_q | (WORD_BITS'(1) << page_q[BIT_W-1:0]);
        res_status_d = ST_OK;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_FILL;
        wcnt_d  = '0;
      end
    endcase

    // a new region size reloads the whole bitmap
    if (cfg_we_i && (cfg_index_i == REG_REGION_PAGES)) begin
      state_d = S_FILL;
      wcnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      wcnt_q      <= '0;
      base_q      <= '0;
      region_q    <= RUN_W'(1024);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      if (cfg_we_i && (cfg_index_i == REG_BASE_ADDRESS)) begin
        base_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_REGION_PAGES)) begin
        region_q <= cfg_data_i[RUN_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    run_q        <= run_d;
    count_q      <= count_d;
    end_q        <= end_d;
    start_q      <= start_d;
    page_q       <= page_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_addr_q};

`ifndef SYNTHESIS
  // the item just taken keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item taken while previous still in work");

  // every page cleared by marking was free
  a_mark_clears_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> ((rdata_q & mark_mask) == mark_mask))
    else $error("marking clears a page that was not free");

  // the scan never walks past the active region
  a_scan_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((RUN_W+1)'(wcnt_q) < n_words))
    else $error("scan beyond active region");

  // failures carry address zero (frees do too, but only failures are checked)
  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |-> (out_addr_q == '0))
    else $error("nonzero address on failed request");
`endif

endmodule

`default_nettype wire
